@@ hdl/fifo_replacement_key_value_cache_defines.svh @@
// Assertion helpers for the key/value cache.
`ifndef FIFO_REPLACEMENT_KEY_VALUE_CACHE_DEFINES_SVH
`define FIFO_REPLACEMENT_KEY_VALUE_CACHE_DEFINES_SVH

// Condition checked on every clock edge outside reset.
`define FKVC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/fkvc_pkg.sv @@
`default_nettype none
package fkvc_pkg;

   localparam int SLOTS    = 16;
   localparam int SlotBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntBits  = $clog2(SLOTS + 1);
   localparam int KeyW     = 32;
   localparam int ValueW   = 64;
   localparam int CountW   = 5;
   localparam logic [CountW-1:0] CountReset = CountW'(16);

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_FIND = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                en;
      logic [SlotBits-1:0] slot;
      logic [KeyW-1:0]     key;
      logic [ValueW-1:0]   value;
   } store_wr_type;

   typedef struct packed {
      logic              valid;
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
   } store_rd_type;

endpackage
`default_nettype wire

@@ hdl/fkvc_store.sv @@
`default_nettype none
module fkvc_store
   import fkvc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire store_wr_type        wr,
   input  wire logic [SlotBits-1:0] rd_idx,
   output store_rd_type             rd
);

   logic [SLOTS-1:0] valid_ff;
   logic [KeyW-1:0]   key_ff   [SLOTS];
   logic [ValueW-1:0] value_ff [SLOTS];
   store_rd_type      rd_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_ff[wr.slot]   <= wr.key;
         value_ff[wr.slot] <= wr.value;
      end
   end

   // registered read: rd_idx is the slot wanted in the next cycle
   always_ff @(posedge clock) begin
      rd_ff.valid <= valid_ff[rd_idx];
      rd_ff.key   <= key_ff[rd_idx];
      rd_ff.value <= value_ff[rd_idx];
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

@@ hdl/fkvc_ctrl.sv @@
`default_nettype none
module fkvc_ctrl
   import fkvc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [KeyW-1:0]     req_key,
   input  wire logic [ValueW-1:0]   req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_status,
   output logic                     rsp_hit,
   output logic [ValueW-1:0]        rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CountW-1:0]   csr_data,
   output store_wr_type             wr,
   output logic                     clear,
   output logic [SlotBits-1:0]      rd_idx,
   input  wire store_rd_type        rd
);

   state_type state_ff, state_in;

   logic [CountW-1:0]  count_ff, count_in;
   logic [CntBits-1:0] write_slot_ff, write_slot_in;
   logic [CntBits-1:0] idx_ff, idx_in;
   logic [KeyW-1:0]    key_ff, key_in;
   logic               pend_status_ff, pend_status_in;
   logic               pend_hit_ff, pend_hit_in;
   logic [ValueW-1:0]  pend_data_ff, pend_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [ValueW-1:0]  rsp_data_ff, rsp_data_in;

   logic [CntBits-1:0] n_eff;
   logic [CntBits-1:0] cur_slot;
   logic [CntBits-1:0] slot_next;
   logic [CntBits-1:0] idx_next;
   logic               req_acc;
   logic               rsp_free;
   logic               add_bad;
   logic               match;
   logic               last;

   // slots in use, clamped to 1..SLOTS
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CntBits'(1);
      end else if (int'(count_ff) > SLOTS) begin
         n_eff = CntBits'(SLOTS);
      end else begin
         n_eff = CntBits'(count_ff);
      end
   end

   always_comb begin
      cur_slot  = (write_slot_ff >= n_eff) ? '0 : write_slot_ff;
      slot_next = cur_slot + CntBits'(1);
      if (slot_next >= n_eff) begin
         slot_next = '0;
      end
      idx_next = idx_ff + CntBits'(1);
      last     = (idx_next >= n_eff);
      match    = rd.valid && (rd.key == key_ff);
      add_bad  = (req_key == '0) || (req_value == '0);
      rsp_free = !rsp_valid_ff || !rsp_stall;
      req_acc  = req_valid && !req_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_kind == KIND_FIND && req_key != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (match || last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a config write goes ahead of a request
            req_stall = csr_valid;
            csr_ready = 1'b1;
         end
         ST_SCAN, ST_RESULT: begin
            req_stall = 1'b1;
            csr_ready = 1'b0;
         end
         default: begin
            req_stall = 1'b1;
            csr_ready = 1'b0;
         end
      endcase
      clear    = csr_valid && csr_ready;
      wr.en    = req_acc && (req_kind == KIND_ADD) && !add_bad;
      wr.slot  = cur_slot[SlotBits-1:0];
      wr.key   = req_key;
      wr.value = req_value;
      rd_idx   = idx_in[SlotBits-1:0];
   end

   // datapath next values
   always_comb begin
      count_in       = count_ff;
      write_slot_in  = write_slot_ff;
      idx_in         = idx_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      pend_hit_in    = pend_hit_ff;
      pend_data_in   = pend_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_data_in    = rsp_data_ff;

      if (clear) begin
         count_in      = csr_data;
         write_slot_in = '0;
      end

      if (req_acc) begin
         key_in         = req_key;
         idx_in         = '0;
         pend_hit_in    = 1'b0;
         pend_data_in   = '0;
         pend_status_in = ((req_kind == KIND_ADD) && add_bad) ? STATUS_REJECT : STATUS_OK;
         if (wr.en) begin
            write_slot_in = slot_next;
         end
      end

      if (state_ff == ST_SCAN) begin
         idx_in = idx_next;
         if (match) begin
            pend_hit_in  = 1'b1;
            pend_data_in = rd.value;
         end
      end

      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_hit_in    = pend_hit_ff;
         rsp_data_in   = pend_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= CountReset;
         write_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         write_slot_ff <= write_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      pend_hit_ff    <= pend_hit_in;
      pend_data_ff   <= pend_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

@@ hdl/fifo_replacement_key_value_cache.sv @@
// Key/value cache, up to 16 slots, ring-order replacement.
// req_ channel: kind (0 add, 1 find), key, value; one transfer per item.
// rsp_ channel: status, hit, data; exactly one transfer per request, in order.
// csr_ channel: one write sets entry_count and empties the table; ready only
//   while no request is in flight. A waiting csr write holds off req_.
// Add, rejected add and find with a zero key: accept leads straight to ST_RESULT,
//   which loads the response once the output register is free.
// Find: one shared key comparator walks slots 0..n-1, one slot per cycle, and
//   stops at the first match; n is the clamped entry_count (1..16).
// Requests: one at a time; req_stall stays high from accept until the response
//   is loaded into the output register, so no new request is taken before then.
// A stalled response holds in the output register; the pending result waits
//   for it, so nothing is dropped.
// Reset (synchronous, active high) empties the table, sets entry_count to 16
//   and drops any pending response.
`default_nettype none
`include "fifo_replacement_key_value_cache_defines.svh"
module fifo_replacement_key_value_cache
   import fkvc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire logic [KeyW-1:0]   req_key,
   input  wire logic [ValueW-1:0] req_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_status,
   output logic                   rsp_hit,
   output logic [ValueW-1:0]      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CountW-1:0] csr_data
);

   store_wr_type        wr;
   store_rd_type        rd;
   logic                clear;
   logic [SlotBits-1:0] rd_idx;

   fkvc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .clear  (clear),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd     (rd)
   );

   fkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_hit    (rsp_hit),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .wr         (wr),
      .clear      (clear),
      .rd_idx     (rd_idx),
      .rd         (rd)
   );

   `FKVC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall,
      "not busy after request")
   `FKVC_ASSERT_ALWAYS(a_reject_clean,
      !(rsp_valid && rsp_status) || (!rsp_hit && rsp_data == '0), "rejected add with payload")
   `FKVC_ASSERT_ALWAYS(a_hit_nonzero, !(rsp_valid && rsp_hit) || (rsp_data != '0),
      "hit with zero data")

endmodule
`default_nettype wire

@@ tb/sv/kv_cache_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module kv_cache_checker
   import fkvc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_kind,
   input  wire logic [KeyW-1:0]   req_key,
   input  wire logic [ValueW-1:0] req_value,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_status,
   input  wire logic              rsp_hit,
   input  wire logic [ValueW-1:0] rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [CountW-1:0] csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     add_count,
   output int                     reject_count,
   output int                     find_count,
   output int                     hit_count
);

   typedef struct packed {
      logic              status;
      logic              hit;
      logic [ValueW-1:0] data;
   } kv_result_type;

   logic [KeyW-1:0]   key_table[SLOTS];
   logic [ValueW-1:0] value_table[SLOTS];
   int unsigned       next_slot;
   logic [CountW-1:0] entry_count;
   kv_result_type     expected_rsp[$];
   int                failures = 0;

   initial begin
      fail_count   = 0;
      pending      = 0;
      add_count    = 0;
      reject_count = 0;
      find_count   = 0;
      hit_count    = 0;
   end

   function automatic int unsigned active_slots();
      if (entry_count == 0) return 1;
      if (entry_count > SLOTS) return SLOTS;
      return entry_count;
   endfunction

   function automatic void clear_table();
      foreach (key_table[i]) begin
         key_table[i]   = '0;
         value_table[i] = '0;
      end
      next_slot = 0;
   endfunction

   // Applies one request to the table copy and returns the response it should give.
   function automatic kv_result_type insert_or_lookup(logic kind, logic [KeyW-1:0] key,
                                                      logic [ValueW-1:0] value);
      kv_result_type r;
      int unsigned   n;
      int unsigned   slot;
      r = '0;
      r.status = STATUS_OK;
      n = active_slots();
      if (kind == KIND_ADD) begin
         if (key == '0 || value == '0) begin
            r.status = STATUS_REJECT;
         end else begin
            slot = (next_slot >= n) ? 0 : next_slot;
            key_table[slot]   = key;
            value_table[slot] = value;
            slot++;
            next_slot = (slot >= n) ? 0 : slot;
         end
      end else if (key != '0) begin
         for (int i = 0; i < n; i++) begin
            if (key_table[i] == key) begin
               r.hit  = 1'b1;
               r.data = value_table[i];
               break;
            end
         end
      end
      return r;
   endfunction

   function automatic void note_failure(string what, kv_result_type want,
                                        kv_result_type got);
      failures++;
      if (failures <= 10)
         $display("%0t ERROR %s: expected st=%0d hit=%0d data=%h, got st=%0d hit=%0d data=%h",
                  $realtime, what, want.status, want.hit, want.data,
                  got.status, got.hit, got.data);
   endfunction

   always @(posedge clock) begin
      kv_result_type want;
      kv_result_type got;
      if (reset) begin
         entry_count = CountReset;
         clear_table();
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            entry_count = csr_data;
            clear_table();
         end
         if (req_valid && !req_stall) begin
            want = insert_or_lookup(req_kind, req_key, req_value);
            expected_rsp.push_back(want);
            if (req_kind == KIND_ADD) begin
               add_count++;
               if (want.status == STATUS_REJECT) reject_count++;
            end else begin
               find_count++;
               if (want.hit) hit_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_hit, rsp_data};
            if (expected_rsp.size() == 0) begin
               note_failure("unexpected response transfer", '0, got);
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) note_failure("response mismatch", want, got);
            end
         end
      end
      fail_count <= failures;
      pending    <= expected_rsp.size();
   end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import fkvc_pkg::*;

   localparam int RandomPerPhase = 100;
   localparam int HoldCycles     = 250;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_kind   = KIND_ADD;
   logic [KeyW-1:0]   req_key    = '0;
   logic [ValueW-1:0] req_value  = '0;
   logic              rsp_stall  = 1'b0;
   logic              csr_valid  = 1'b0;
   logic [CountW-1:0] csr_data   = '0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_status;
   logic              rsp_hit;
   logic [ValueW-1:0] rsp_data;
   logic              csr_ready;

   int fail_count;
   int pending;
   int add_count;
   int reject_count;
   int find_count;
   int hit_count;

   int phase_no  = 0;
   bit quiet     = 1'b0;
   bit rsp_hold  = 1'b0;

   logic [KeyW-1:0]   recent_keys[$];
   logic [CountW-1:0] count_plan[9] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd5, 5'd3,
                                        5'd15};

   fifo_replacement_key_value_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_hit    (rsp_hit),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   kv_cache_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_key      (req_key),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_hit      (rsp_hit),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .add_count    (add_count),
      .reject_count (reject_count),
      .find_count   (find_count),
      .hit_count    (hit_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off that backs up the request side.
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || (!quiet && $urandom_range(99) < 32);
   end

   initial begin
      wait (phase_no == 3);
      repeat (20) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic send_item(logic kind, logic [KeyW-1:0] key, logic [ValueW-1:0] value);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (kind == KIND_ADD && key != '0) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      end
   endtask

   task automatic send_random_item();
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
      int                pick;
      if (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      pick = $urandom_range(99);
      if (pick < 5)
         key = '0;
      else if (pick < 50 && recent_keys.size() > 0)
         key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (pick < 65)
         key = $urandom_range(1, 8);
      else
         key = $urandom;
      pick = $urandom_range(99);
      if (pick < 5)
         value = '0;
      else if (pick < 10)
         value = '1;
      else
         value = {$urandom, $urandom};
      send_item(($urandom_range(1) != 0) ? KIND_FIND : KIND_ADD, key, value);
   endtask

   task automatic drain();
      int waited;
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_entry_count(logic [CountW-1:0] count);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, rejects, field extremes, duplicate keys
      send_item(KIND_FIND, '0, '0);
      send_item(KIND_FIND, 32'hDEAD_BEEF, '0);
      send_item(KIND_ADD, '0, '1);
      send_item(KIND_ADD, '1, '0);
      send_item(KIND_ADD, '0, '0);
      send_item(KIND_ADD, '1, '1);
      send_item(KIND_FIND, '1, '0);
      send_item(KIND_ADD, 32'd1, 64'd1);
      send_item(KIND_ADD, 32'd1, 64'h8000_0000_0000_0000);
      send_item(KIND_FIND, 32'd1, '1);
      send_item(KIND_FIND, '0, '1);
      send_item(KIND_ADD, 32'h8000_0000, 64'd1);
      send_item(KIND_FIND, 32'h8000_0000, '0);
      send_item(KIND_FIND, 32'd2, '0);
      send_item(KIND_FIND, 32'hFFFF_FFFE, '0);

      for (int p = 0; p <= 10; p++) begin
         if (p > 0) begin
            drain();
            write_entry_count((p <= 9) ? count_plan[p - 1] : CountW'($urandom_range(0, 31)));
            recent_keys.delete();
         end
         phase_no = p;
         quiet    = (p == 6);
         for (int i = 0; i < RandomPerPhase; i++) send_random_item();
      end
      drain();

      $display("Covered %0d adds (%0d rejected) and %0d finds (%0d hits) over 11 table sizes,",
               add_count, reject_count, find_count, hit_count);
      $display("including random stalls, a quiet stretch and a %0d-cycle response hold-off.",
               HoldCycles);
      if (pending != 0)
         $display("ERROR %0d responses never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/fkvc_pkg.sv
hdl/fkvc_store.sv
hdl/fkvc_ctrl.sv
hdl/fifo_replacement_key_value_cache.sv
tb/sv/kv_cache_checker.sv
tb/sv/testbench.sv
